// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// consequence holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// consequence holds in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/rpa_pkg.sv -----
// ----------------------------------------------------------------------------
// rpa_pkg
// Types and constants shared by the page allocator modules
// ----------------------------------------------------------------------------
package rpa_pkg;

  // fixed field widths
  localparam int PAGE_W = 15;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 3;
  localparam int RCNT_W = 8;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_ADDREF = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STS_OK    = 3'd0,
    STS_OOM   = 3'd1,
    STS_RANGE = 3'd2,
    STS_ZERO  = 3'd3,
    STS_SAT   = 3'd4
  } status_t;

  // classified request held in the queue
  typedef struct packed {
    req_t              req;
    logic [PAGE_W-1:0] page;
    logic              out_of_range;
  } qent_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

endpackage

// ----- design/rpa_in_if.sv -----
// ----------------------------------------------------------------------------
// rpa_in_if
// Request channel: valid/ready handshake with request type and page index
// ----------------------------------------------------------------------------
interface rpa_in_if import rpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [PAGE_W-1:0] page_index;

  modport source (output valid, output req_type, output page_index, input ready);
  modport sink   (input valid, input req_type, input page_index, output ready);
endinterface

// ----- design/rpa_out_if.sv -----
// ----------------------------------------------------------------------------
// rpa_out_if
// Result channel: valid/ready handshake with status, page, count and release
// ----------------------------------------------------------------------------
interface rpa_out_if import rpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [PAGE_W-1:0] result_page;
  logic [RCNT_W-1:0] ref_count;
  logic              page_released;

  modport source (output valid, output status, output result_page, output ref_count,
                  output page_released, input ready);
  modport sink   (input valid, input status, input result_page, input ref_count,
                  input page_released, output ready);
endinterface

// ----- design/refcounted_page_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// refcounted_page_allocator_unit
// Page frame allocator with a LIFO free page stack and per-page ref counts
// ----------------------------------------------------------------------------
// Requests enter on in_ch (allocate, free, add reference, read count) and
// each gives exactly one result item on out_ch, in request order.
// cfg_we/cfg_wdata set the lowest page index that free accepts; write it
// only while no request is in flight.
// A front stage range-checks each item into a two-entry queue; a back stage
// reads the count memory and the stack top in one cycle and writes back and
// registers the result in the next, so the back takes no new item until it
// has written back the last one, set by the read then write of the count
// memory for each item. An accepted request passes the queue entry, the read
// registers and the result register before its result is valid.
// After reset the back sweeps every count memory entry to one, with
// in_ch.ready low; the free stack starts empty.
// When out_ch stalls the result is held, the back stops taking items and
// the queue absorbs up to two more before in_ch.ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module refcounted_page_allocator_unit import rpa_pkg::*; #(
  parameter int NUM_PAGES  = 32768,
  parameter int COUNT_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [PAGE_W-1:0] cfg_wdata,
  rpa_in_if.sink            in_ch,
  rpa_out_if.source         out_ch
);

  qstat_t q_stat;
  qent_t  q_ent_in;
  qent_t  q_ent_out;
  logic   q_push;
  logic   q_pop;
  logic   clearing;

  // accept and classify
  rpa_front #(
    .NUM_PAGES (NUM_PAGES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .clearing  (clearing),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_ent     (q_ent_in)
  );

  // decoupling queue
  rpa_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .ent_in  (q_ent_in),
    .pop     (q_pop),
    .ent_out (q_ent_out),
    .stat    (q_stat)
  );

  // execute against memories
  rpa_back #(
    .NUM_PAGES  (NUM_PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_ent    (q_ent_out),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

  // no item enters before the count memory sweep is done
  `ASSERT_IMPL(a_no_accept_in_clear, clearing, !in_ch.ready)
  // the back only takes an item the queue holds
  `ASSERT_IMPL(a_pop_needs_entry, q_pop, q_stat.valid)
  // the sweep runs once after reset and never restarts
  `ASSERT_NEXT(a_clear_once, !clearing, !clearing)

endmodule

// ----- design/rpa_front.sv -----
// ----------------------------------------------------------------------------
// rpa_front
// Accepts request items, holds the first free page register and range-checks
// ----------------------------------------------------------------------------
module rpa_front import rpa_pkg::*; #(
  parameter int NUM_PAGES = 32768
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [PAGE_W-1:0] cfg_wdata,
  rpa_in_if.sink            in_ch,
  input  logic              clearing,
  input  qstat_t            q_stat,
  output logic              q_push,
  output qent_t             q_ent
);

  localparam int NP_W = 21;
  localparam logic [NP_W-1:0] NP_LIMIT = NP_W'(NUM_PAGES);

  logic [PAGE_W-1:0] first_free_r;
  logic [NP_W-1:0]   page_ext;
  logic              above_top;
  logic              below_first;
  req_t              req;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_free_r <= '0;
    end else if (cfg_we) begin
      first_free_r <= cfg_wdata;
    end
  end

  // accept while the queue has room and the count memory is initialized
  assign in_ch.ready = !q_stat.full && !clearing;
  assign q_push      = in_ch.valid && in_ch.ready;

  // range classification
  assign req         = req_t'(in_ch.req_type);
  assign page_ext    = {{(NP_W-PAGE_W){1'b0}}, in_ch.page_index};
  assign above_top   = page_ext >= NP_LIMIT;
  assign below_first = in_ch.page_index < first_free_r;

  always_comb begin
    q_ent.req          = req;
    q_ent.page         = in_ch.page_index;
    q_ent.out_of_range = ((req != REQ_ALLOC) && above_top) ||
                         ((req == REQ_FREE) && below_first);
  end

endmodule

// ----- design/rpa_queue.sv -----
// ----------------------------------------------------------------------------
// rpa_queue
// Two-entry queue of classified requests between the front and the back
// ----------------------------------------------------------------------------
module rpa_queue import rpa_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  qent_t  ent_in,
  input  logic   pop,
  output qent_t  ent_out,
  output qstat_t stat
);

  qent_t       ent_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;

  assign stat.valid = cnt_r != 2'd0;
  assign stat.full  = cnt_r == 2'd2;
  assign ent_out    = ent_r[rd_ptr_r];

  // occupancy update
  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= ent_in;
    end
  end

endmodule

// ----- design/rpa_back.sv -----
// ----------------------------------------------------------------------------
// rpa_back
// Executes requests against the count memory and the free page stack
// ----------------------------------------------------------------------------
module rpa_back import rpa_pkg::*; #(
  parameter int NUM_PAGES  = 32768,
  parameter int COUNT_BITS = 8
) (
  input  logic   clk,
  input  logic   rst_n,
  input  qstat_t q_stat,
  input  qent_t  q_ent,
  output logic   q_pop,
  output logic   clearing,
  rpa_out_if.source out_ch
);

  localparam int PIDX_W = $clog2(NUM_PAGES);
  localparam int FILL_W = $clog2(NUM_PAGES + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
  localparam logic [PIDX_W-1:0]     LAST_IDX = PIDX_W'(NUM_PAGES - 1);
  localparam logic [FILL_W-1:0]     FILL_TOP = FILL_W'(NUM_PAGES);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  // page number to memory index, zero-extended or truncated
  function automatic logic [PIDX_W-1:0] to_idx(input logic [PAGE_W-1:0] p);
    logic [PIDX_W+PAGE_W-1:0] w;
    w = {{PIDX_W{1'b0}}, p};
    return w[PIDX_W-1:0];
  endfunction

  // count to the low bits shown on the result
  function automatic logic [RCNT_W-1:0] to_rcnt(input logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS+RCNT_W-1:0] w;
    w = {{RCNT_W{1'b0}}, c};
    return w[RCNT_W-1:0];
  endfunction

  // memories
  logic [COUNT_BITS-1:0] cnt_mem [NUM_PAGES];
  logic [PAGE_W-1:0]     stk_mem [NUM_PAGES];

  state_t                state_r;
  logic [PIDX_W-1:0]     clr_addr_r;
  logic [FILL_W-1:0]     fill_r;
  logic [FILL_W-1:0]     fill_nxt;
  logic [FILL_W-1:0]     fill_dec;
  qent_t                 cur_r;
  logic [COUNT_BITS-1:0] cnt_rd_r;
  logic [PAGE_W-1:0]     stk_rd_r;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [PAGE_W-1:0]     out_page_r;
  logic [RCNT_W-1:0]     out_cnt_r;
  logic                  out_rel_r;

  status_t               res_status;
  logic [PAGE_W-1:0]     res_page;
  logic [COUNT_BITS-1:0] res_cnt;
  logic                  res_rel;
  logic                  cnt_we;
  logic [PIDX_W-1:0]     cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic                  stk_we;
  logic [COUNT_BITS-1:0] cnt_dec;

  assign clearing = state_r == S_CLEAR;
  assign fill_dec = fill_r - 1'b1;
  assign cnt_dec  = cnt_rd_r - 1'b1;

  // take a request when the result slot will be free by the execute cycle
  assign q_pop = (state_r == S_IDLE) && q_stat.valid && (!out_valid_r || out_ch.ready);

  // execute: decide result, count write and stack update
  always_comb begin
    res_status = STS_OK;
    res_page   = cur_r.page;
    res_cnt    = '0;
    res_rel    = 1'b0;
    cnt_we     = 1'b0;
    cnt_waddr  = to_idx(cur_r.page);
    cnt_wdata  = cnt_rd_r;
    stk_we     = 1'b0;
    fill_nxt   = fill_r;
    if (state_r == S_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_addr_r;
      cnt_wdata = CNT_ONE;
    end else if (state_r == S_EXEC) begin
      if (cur_r.out_of_range) begin
        res_status = STS_RANGE;
      end else begin
        case (cur_r.req)
          REQ_ALLOC: begin
            if (fill_r == '0) begin
              res_status = STS_OOM;
              res_page   = '0;
            end else begin
              fill_nxt  = fill_dec;
              res_page  = stk_rd_r;
              res_cnt   = CNT_ONE;
              cnt_we    = 1'b1;
              cnt_waddr = to_idx(stk_rd_r);
              cnt_wdata = CNT_ONE;
            end
          end
          REQ_FREE: begin
            if (cnt_rd_r == '0) begin
              res_status = STS_ZERO;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_dec;
              res_cnt   = cnt_dec;
              // last reference gone: release and push unless the stack is full
              if (cnt_dec == '0) begin
                res_rel = 1'b1;
                if (fill_r != FILL_TOP) begin
                  stk_we   = 1'b1;
                  fill_nxt = fill_r + 1'b1;
                end
              end
            end
          end
          REQ_ADDREF: begin
            res_cnt = cnt_rd_r;
            if (cnt_rd_r == CNT_MAX) begin
              res_status = STS_SAT;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_rd_r + 1'b1;
              res_cnt   = cnt_rd_r + 1'b1;
            end
          end
          REQ_READ: begin
            res_cnt = cnt_rd_r;
          end
          default: begin
            res_cnt = cnt_rd_r;
          end
        endcase
      end
    end
  end

  // count memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (q_pop) begin
      cnt_rd_r <= cnt_mem[to_idx(q_ent.page)];
    end
  end

  // free page stack: push at fill, read top for a possible pop
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[fill_r[PIDX_W-1:0]] <= cur_r.page;
    end
    if (q_pop) begin
      stk_rd_r <= stk_mem[fill_dec[PIDX_W-1:0]];
    end
  end

  // sequencer, stack fill and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result slot: loaded on execute, emptied once taken
      if (state_r == S_EXEC) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == LAST_IDX) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            cur_r   <= q_ent;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          fill_r       <= fill_nxt;
          out_status_r <= res_status;
          out_page_r   <= res_page;
          out_cnt_r    <= to_rcnt(res_cnt);
          out_rel_r    <= res_rel;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.result_page   = out_page_r;
  assign out_ch.ref_count     = out_cnt_r;
  assign out_ch.page_released = out_rel_r;

endmodule

// ----- tb/refcounted_page_allocator_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// refcounted_page_allocator_unit_tb
// Self-checking bench for the page allocator with per-page ref counts
// ----------------------------------------------------------------------------
// A local copy of the allocator state (free page stack, fill level, count
// per page, lowest freeable page) predicts one result item per accepted
// request. A checker compares every result item field by field, in order.
// Tests cover the empty stack, the free bounds at several settings, stale
// stack entries, count saturation, output back-pressure and random request
// mixes.
// ----------------------------------------------------------------------------
module refcounted_page_allocator_unit_tb;
  import rpa_pkg::*;

  localparam int NUM_PAGES     = 32768;
  localparam int COUNT_BITS    = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 4 * NUM_PAGES + 1000;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // one result item as the block should return it
  typedef struct packed {
    status_t                status;
    logic [PAGE_W-1:0]      page;
    logic [RCNT_W-1:0]      count;
    logic                   released;
  } page_reply_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [PAGE_W-1:0] cfg_wdata;

  rpa_in_if  req_ch ();
  rpa_out_if rsp_ch ();

  refcounted_page_allocator_unit #(
    .NUM_PAGES  (NUM_PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch)
  );

  // local allocator state
  logic [PAGE_W-1:0]     free_pages [NUM_PAGES];
  int                    free_fill;
  logic [COUNT_BITS-1:0] page_counts [NUM_PAGES];
  logic [PAGE_W-1:0]     lowest_freeable;

  page_reply_t replies_due [$];
  int          mismatches = 0;
  int          feed_gap_pct = 0;
  int          sink_gap_pct = 0;
  int          hold_request = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // allocator behavior for one request, updates the local state
  function automatic page_reply_t apply_page_request(req_t kind, logic [PAGE_W-1:0] page);
    page_reply_t           r;
    logic [COUNT_BITS-1:0] cnt;
    r = '{status: STS_OK, page: page, count: '0, released: 1'b0};
    if (kind == REQ_ALLOC) begin
      if (free_fill == 0) begin
        r.status = STS_OOM;
        r.page   = '0;
      end else begin
        free_fill--;
        r.page = free_pages[free_fill];
        page_counts[r.page] = COUNT_BITS'(1);
        r.count = RCNT_W'(1);
      end
      return r;
    end
    if (int'(page) >= NUM_PAGES) begin
      r.status = STS_RANGE;
      return r;
    end
    cnt = page_counts[page];
    case (kind)
      REQ_FREE: begin
        if (page < lowest_freeable) begin
          r.status = STS_RANGE;
        end else if (cnt == 0) begin
          r.status = STS_ZERO;
        end else begin
          cnt--;
          page_counts[page] = cnt;
          if (cnt == 0) begin
            // a full stack drops the push but the page still counts as released
            if (free_fill < NUM_PAGES) begin
              free_pages[free_fill] = page;
              free_fill++;
            end
            r.released = 1'b1;
          end else begin
            r.count = cnt;
          end
        end
      end
      REQ_ADDREF: begin
        if (cnt >= COUNT_MAX) begin
          r.status = STS_SAT;
          r.count  = cnt;
        end else begin
          cnt++;
          page_counts[page] = cnt;
          r.count = cnt;
        end
      end
      default: r.count = cnt;
    endcase
    return r;
  endfunction

  // offer one item, predict it once accepted, then maybe pause
  task automatic issue_request(req_t kind, logic [PAGE_W-1:0] page);
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.page_index <= page;
    do @(posedge clk);
    while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
    replies_due.push_back(apply_page_request(kind, page));
    if (feed_gap_pct > 0 && $urandom_range(0, 99) < feed_gap_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every result item is back
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only while the block is idle
  task automatic set_lowest_freeable(logic [PAGE_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    lowest_freeable = value;
  endtask

  task automatic test_directed_cases();
    set_lowest_freeable(16);
    issue_request(REQ_ALLOC, 15'h7fff);      // empty stack
    issue_request(REQ_READ, 15'h0000);
    issue_request(REQ_READ, 15'h7fff);
    issue_request(REQ_FREE, 15);             // just below the bound
    issue_request(REQ_FREE, 16);             // released
    issue_request(REQ_FREE, 16);             // count already zero
    issue_request(REQ_READ, 16);
    issue_request(REQ_ADDREF, 0);            // no lower bound on add
    issue_request(REQ_FREE, 15'h7fff);
    issue_request(REQ_ALLOC, 15'h2aaa);
    issue_request(REQ_ALLOC, 15'h5555);
    issue_request(REQ_ALLOC, 15'h0000);      // empty again
    // add reference on a page that sits on the stack
    issue_request(REQ_FREE, 40);
    issue_request(REQ_ADDREF, 40);
    issue_request(REQ_ALLOC, 15'h1234);
    issue_request(REQ_ADDREF, 40);
    issue_request(REQ_FREE, 40);
    settle();
    set_lowest_freeable(15'h7fff);
    issue_request(REQ_FREE, 15'h7ffe);
    issue_request(REQ_FREE, 15'h7fff);
    issue_request(REQ_ALLOC, 15'h0000);
    settle();
    set_lowest_freeable(0);
    issue_request(REQ_FREE, 0);
    issue_request(REQ_FREE, 0);
    issue_request(REQ_ALLOC, 15'h7fff);
    settle();
  endtask

  task automatic test_count_saturation();
    logic [PAGE_W-1:0] page;
    page = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
    while (page_counts[page] < COUNT_MAX) issue_request(REQ_ADDREF, page);
    issue_request(REQ_ADDREF, page);
    issue_request(REQ_ADDREF, page);
    issue_request(REQ_READ, page);
    repeat (3) issue_request(REQ_FREE, page);
    settle();
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_result_backpressure();
    feed_gap_pct = 0;
    hold_request = 60;
    repeat (16) begin
      issue_request($urandom_range(0, 1) ? REQ_READ : REQ_ADDREF,
                    PAGE_W'($urandom_range(0, NUM_PAGES - 1)));
    end
    settle();
  endtask

  task automatic test_random_mix(int n_items, logic [PAGE_W-1:0] bound, int feed_gap,
                                 int sink_gap);
    logic [PAGE_W-1:0] hot_pages [16];
    logic [PAGE_W-1:0] last_granted;
    logic [PAGE_W-1:0] page;
    req_t              kind;
    int                pick;
    set_lowest_freeable(bound);
    feed_gap_pct = feed_gap;
    sink_gap_pct = sink_gap;
    foreach (hot_pages[i])
      hot_pages[i] = PAGE_W'(int'(bound) + $urandom_range(0, NUM_PAGES - 1 - int'(bound)));
    last_granted = hot_pages[0];
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) kind = REQ_ALLOC;
      else if (pick < 55) kind = REQ_FREE;
      else if (pick < 75) kind = REQ_ADDREF;
      else kind = REQ_READ;
      // mostly pages with history, some near the bound, some anywhere
      pick = $urandom_range(0, 99);
      if (pick < 40) page = hot_pages[$urandom_range(0, 15)];
      else if (pick < 60) page = last_granted;
      else if (pick < 75) page = (bound > 0 && pick < 68) ? bound - 1'b1 : bound;
      else page = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
      if (kind == REQ_ALLOC) begin
        page = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
        if (free_fill > 0) last_granted = free_pages[free_fill - 1];
      end
      issue_request(kind, page);
    end
    settle();
  endtask

  // result side: random stalls and the long hold-off
  initial begin : result_sink
    int len;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        len = hold_request;
        hold_request = 0;
        rsp_ch.ready <= 1'b0;
        repeat (len - 1) @(posedge clk);
      end else if (sink_gap_pct > 0 && $urandom_range(0, 99) < sink_gap_pct) begin
        len = $urandom_range(1, 10);
        rsp_ch.ready <= 1'b0;
        repeat (len - 1) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // compare each result item with the oldest prediction
  always @(posedge clk) begin : reply_checker
    page_reply_t due;
    if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (replies_due.size() == 0) begin
        $error("result item with nothing expected: status %0d page %0d",
               rsp_ch.status, rsp_ch.result_page);
        mismatches++;
      end else begin
        due = replies_due.pop_front();
        if (rsp_ch.status !== due.status) begin
          $error("status mismatch: expected %0d, actual %0d", due.status, rsp_ch.status);
          mismatches++;
        end
        if (rsp_ch.result_page !== due.page) begin
          $error("result_page mismatch: expected %0d, actual %0d",
                 due.page, rsp_ch.result_page);
          mismatches++;
        end
        if (rsp_ch.ref_count !== due.count) begin
          $error("ref_count mismatch: expected %0d, actual %0d", due.count, rsp_ch.ref_count);
          mismatches++;
        end
        if (rsp_ch.page_released !== due.released) begin
          $error("page_released mismatch: expected %0d, actual %0d",
                 due.released, rsp_ch.page_released);
          mismatches++;
        end
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin : stall_watch
    int quiet_cycles;
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("refcounted_page_allocator_unit verification failed");
        $finish;
      end
    end
  end

  initial begin : run_tests
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_ALLOC;
    req_ch.page_index <= '0;
    free_fill       = 0;
    lowest_freeable = '0;
    foreach (page_counts[i]) page_counts[i] = COUNT_BITS'(1);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // count memory is being cleared until ready rises
    do @(posedge clk);
    while (req_ch.ready !== 1'b1);

    test_directed_cases();
    feed_gap_pct = 20;
    sink_gap_pct = 20;
    test_count_saturation();
    test_result_backpressure();
    test_random_mix(180, 0, 20, 20);
    test_random_mix(180, PAGE_W'($urandom_range(1, NUM_PAGES - 2)), 25, 15);
    test_random_mix(60, 15'h7fff, 15, 25);
    test_random_mix(150, PAGE_W'($urandom_range(0, 255)), 20, 20);
    test_random_mix(180, PAGE_W'($urandom_range(0, 4095)), 0, 0);

    settle();
    if (mismatches == 0) begin
      $display("refcounted_page_allocator_unit verification clean");
    end else begin
      $display("refcounted_page_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
